// ----- src/llbl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package llbl_pkg;

    // Default sizing
    localparam int DEF_MAX_ROWS    = 4096;
    localparam int DEF_MAX_RECORDS = 65536;
    localparam int DEF_BIN_BITS    = 24;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_ROW   = 2'd0,
        KIND_REC   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // Config register indexes
    typedef enum logic {
        CFG_ROWS    = 1'b0,
        CFG_RECORDS = 1'b1
    } t_cfg_idx;

    localparam logic [12:0] DEF_ROW_COUNT = 13'd2160;
    localparam logic [16:0] DEF_REC_COUNT = 17'd1;

    // Row size storage
    localparam int          SIZE_W   = 13;
    localparam logic [12:0] SIZE_SAT = 13'd8191;

    // Angles in 1/65536 degree
    localparam logic signed [26:0] QUARTER_TURN = 27'sd5898240;
    localparam logic signed [26:0] HALF_TURN    = 27'sd11796480;
    localparam logic signed [26:0] FULL_TURN    = 27'sd23592960;

    // Shared multiplier
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    // Reciprocals scaled by 2^32, rounded up; exact floor for 22-bit dividends
    localparam longint unsigned RECIP_180_L = ((64'd1 << 32) + 64'd179) / 64'd180;
    localparam longint unsigned RECIP_360_L = ((64'd1 << 32) + 64'd359) / 64'd360;
    localparam logic [MUL_W-1:0] RECIP_180 = RECIP_180_L[MUL_W-1:0];
    localparam logic [MUL_W-1:0] RECIP_360 = RECIP_360_L[MUL_W-1:0];

    typedef struct packed {
        logic [MUL_W-1:0] op_a;
        logic [MUL_W-1:0] op_b;
    } t_mul_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW_MUL,
        S_ROW_DIV,
        S_ROW_RD,
        S_COL_MUL,
        S_COL_DIV,
        S_BIN,
        S_END_RD,
        S_FIRST_RD,
        S_SEARCH,
        S_CK0,
        S_CK1,
        S_CK2
    } t_state;

endpackage
`default_nettype wire

// ----- src/llbl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module llbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- src/llbl_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module llbl_mul (
    input  wire logic                          i_clk,
    input  wire llbl_pkg::t_mul_req            i_req,
    output logic      [llbl_pkg::PROD_W-1:0]   o_prod
);
    logic [llbl_pkg::PROD_W-1:0] r_prod;

    // shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= {{llbl_pkg::MUL_W{1'b0}}, i_req.op_a} * {{llbl_pkg::MUL_W{1'b0}}, i_req.op_b};
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

// ----- src/latlon_bin_lookup.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Loads (row or record) never raise busy. A query holds busy until its result is ready;
// a new query is accepted only while busy is low, and an empty table skips the search.
// One multiplier is reused for the row and column products and the reciprocal divides;
// the record memory port is read once per search step. The strobe comes as busy drops.
// Results cannot be stalled. Synchronous active-low reset clears sequencer, base, config.
module latlon_bin_lookup #(
    parameter int MAX_ROWS    = llbl_pkg::DEF_MAX_ROWS,
    parameter int MAX_RECORDS = llbl_pkg::DEF_MAX_RECORDS,
    parameter int BIN_BITS    = llbl_pkg::DEF_BIN_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         i_kind,
    input  wire logic [11:0]        i_row_index,
    input  wire logic [13:0]        i_row_bins,
    input  wire logic [15:0]        i_record_index,
    input  wire logic [23:0]        i_bin_number,
    input  wire logic [31:0]        i_value,
    input  wire logic signed [24:0] i_lat,
    input  wire logic signed [24:0] i_lon,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [16:0]        i_cfg_data,
    output logic                    busy,
    output logic                    o_strobe,
    output logic                    o_found,
    output logic [23:0]             o_grid_bin,
    output logic [15:0]             o_match_index,
    output logic [31:0]             o_match_value
);
    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int REC_AW = $clog2(MAX_RECORDS);
    localparam int SW     = REC_AW + 2;
    localparam int ROW_DW = llbl_pkg::SIZE_W + BIN_BITS;
    localparam int REC_DW = BIN_BITS + 32;
    localparam int MW     = llbl_pkg::MUL_W;
    localparam logic signed [SW-1:0] S_ONE  = SW'(1);
    localparam logic signed [SW-1:0] S_NEG1 = '1;
    localparam logic [BIN_BITS-1:0]  BIN_ONE = BIN_BITS'(1);

    llbl_pkg::t_state r_state, n_state;

    logic [12:0]         r_row_count;
    logic [16:0]         r_rec_count;
    logic [BIN_BITS-1:0] r_run_base;
    logic [23:0]         r_a;
    logic [24:0]         r_b;
    logic [12:0]         r_size;
    logic [BIN_BITS-1:0] r_base;
    logic [BIN_BITS-1:0] r_bin;
    logic [BIN_BITS-1:0] r_first_bin, r_last_bin, r_c0_bin, r_c1_bin;
    logic [31:0]         r_first_val, r_last_val, r_c0_val, r_c1_val;
    logic                r_up;
    logic signed [SW-1:0] r_lo, r_hi, r_mid;
    logic                r_strobe, r_found;
    logic [23:0]         r_grid;
    logic [15:0]         r_idx;
    logic [31:0]         r_val;

    logic accept;
    logic [13:0] rows_eff;
    logic signed [SW-1:0] n_eff;

    assign accept = start && !busy;
    assign busy   = (r_state != llbl_pkg::S_IDLE);

    // effective row and record counts
    always_comb begin
        logic [31:0] cnt32;
        cnt32 = 32'(r_rec_count);
        if (r_row_count == '0) begin
            rows_eff = 14'd1;
        end else if (14'(r_row_count) > 14'(MAX_ROWS)) begin
            rows_eff = 14'(MAX_ROWS);
        end else begin
            rows_eff = 14'(r_row_count);
        end
        if (cnt32 > 32'(MAX_RECORDS)) begin
            n_eff = SW'(MAX_RECORDS);
        end else begin
            n_eff = SW'(cnt32);
        end
    end

    // loads
    logic                row_we, rec_we;
    logic [12:0]         size_sat;
    logic [BIN_BITS-1:0] base_use;

    always_comb begin
        size_sat = (i_row_bins > 14'(llbl_pkg::SIZE_SAT)) ? llbl_pkg::SIZE_SAT
                                                         : i_row_bins[12:0];
        base_use = (i_row_index == '0) ? BIN_ONE : r_run_base;
        row_we   = accept && (i_kind == llbl_pkg::KIND_ROW)
                   && (32'(i_row_index) < 32'(MAX_ROWS));
        rec_we   = accept && (i_kind == llbl_pkg::KIND_REC)
                   && (32'(i_record_index) < 32'(MAX_RECORDS));
    end

    // query position: clamp latitude, wrap longitude
    logic signed [26:0] lat_x, lon_x, lat_c, lon_w, a_val, b_val;

    always_comb begin
        lat_x = 27'(i_lat);
        lon_x = 27'(i_lon);
        if (lat_x > llbl_pkg::QUARTER_TURN) begin
            lat_c = llbl_pkg::QUARTER_TURN;
        end else if (lat_x < -llbl_pkg::QUARTER_TURN) begin
            lat_c = -llbl_pkg::QUARTER_TURN;
        end else begin
            lat_c = lat_x;
        end
        if (lon_x < -llbl_pkg::HALF_TURN) begin
            lon_w = lon_x + llbl_pkg::FULL_TURN;
        end else if (lon_x > llbl_pkg::HALF_TURN) begin
            lon_w = lon_x - llbl_pkg::FULL_TURN;
        end else begin
            lon_w = lon_x;
        end
        a_val = lat_c + llbl_pkg::QUARTER_TURN;
        b_val = lon_w + llbl_pkg::HALF_TURN;
    end

    // memories and shared multiplier
    logic [ROW_AW-1:0]            row_raddr;
    logic [ROW_DW-1:0]            row_rdata;
    logic [REC_AW-1:0]            rec_raddr;
    logic [REC_DW-1:0]            rec_rdata;
    llbl_pkg::t_mul_req           mul_req;
    logic [llbl_pkg::PROD_W-1:0]  prod;

    llbl_ram #(.WIDTH(ROW_DW), .DEPTH(MAX_ROWS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (ROW_AW'(i_row_index)),
        .i_wdata ({size_sat, base_use}),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    llbl_ram #(.WIDTH(REC_DW), .DEPTH(MAX_RECORDS)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (REC_AW'(i_record_index)),
        .i_wdata ({BIN_BITS'(i_bin_number), i_value}),
        .i_raddr (rec_raddr),
        .o_rdata (rec_rdata)
    );

    llbl_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // datapath helpers
    logic [13:0]          quot;
    logic [13:0]          row_sel;
    logic [12:0]          rd_size;
    logic [BIN_BITS-1:0]  rd_base, d_bin, bin_calc;
    logic [31:0]          d_val;
    logic                 go_lo, search_more;
    logic signed [SW-1:0] s_lo, s_hi, s_mid, first_mid;
    logic signed [SW:0]   s_sum, f_sum;
    logic                 hit;
    logic signed [SW-1:0] hit_idx;
    logic [31:0]          hit_val;

    always_comb begin
        quot    = prod[45:32];
        row_sel = (quot >= rows_eff) ? (rows_eff - 14'd1) : quot;
        rd_size = row_rdata[ROW_DW-1 -: llbl_pkg::SIZE_W];
        rd_base = row_rdata[BIN_BITS-1:0];
        d_bin   = rec_rdata[REC_DW-1 -: BIN_BITS];
        d_val   = rec_rdata[31:0];

        // bin from row base and clamped column
        if (quot >= 14'(r_size)) begin
            if (r_size == '0) begin
                bin_calc = r_base - BIN_ONE;
            end else begin
                bin_calc = r_base + BIN_BITS'(r_size) - BIN_ONE;
            end
        end else begin
            bin_calc = r_base + BIN_BITS'(quot);
        end

        // one binary search step
        go_lo       = (r_up == (r_bin >= d_bin));
        s_lo        = go_lo ? r_mid : r_lo;
        s_hi        = go_lo ? r_hi : r_mid;
        search_more = (s_hi - s_lo) > S_ONE;
        s_sum       = {s_lo[SW-1], s_lo} + {s_hi[SW-1], s_hi};
        s_mid       = s_sum[SW:1];
        f_sum       = {n_eff[SW-1], n_eff} - (SW+1)'(1);
        first_mid   = f_sum[SW:1];

        // neighbor checks in priority order
        hit     = 1'b1;
        hit_idx = r_lo;
        hit_val = r_c0_val;
        if ((r_lo >= 0) && (r_bin == r_c0_bin)) begin
            hit_idx = r_lo;
            hit_val = r_c0_val;
        end else if (((r_lo + S_ONE) < n_eff) && (r_bin == r_c1_bin)) begin
            hit_idx = r_lo + S_ONE;
            hit_val = r_c1_val;
        end else if ((r_lo > 0) && (r_bin == d_bin)) begin
            hit_idx = r_lo - S_ONE;
            hit_val = d_val;
        end else if (r_bin == r_first_bin) begin
            hit_idx = '0;
            hit_val = r_first_val;
        end else if (r_bin == r_last_bin) begin
            hit_idx = n_eff - S_ONE;
            hit_val = r_last_val;
        end else begin
            hit     = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            llbl_pkg::S_IDLE: begin
                if (accept && (i_kind == llbl_pkg::KIND_QUERY)) begin
                    n_state = llbl_pkg::S_ROW_MUL;
                end
            end
            llbl_pkg::S_ROW_MUL:  n_state = llbl_pkg::S_ROW_DIV;
            llbl_pkg::S_ROW_DIV:  n_state = llbl_pkg::S_ROW_RD;
            llbl_pkg::S_ROW_RD:   n_state = llbl_pkg::S_COL_MUL;
            llbl_pkg::S_COL_MUL:  n_state = llbl_pkg::S_COL_DIV;
            llbl_pkg::S_COL_DIV:  n_state = llbl_pkg::S_BIN;
            llbl_pkg::S_BIN: begin
                n_state = (n_eff == '0) ? llbl_pkg::S_IDLE : llbl_pkg::S_END_RD;
            end
            llbl_pkg::S_END_RD:   n_state = llbl_pkg::S_FIRST_RD;
            llbl_pkg::S_FIRST_RD: n_state = llbl_pkg::S_SEARCH;
            llbl_pkg::S_SEARCH: begin
                if (!search_more) begin
                    n_state = llbl_pkg::S_CK0;
                end
            end
            llbl_pkg::S_CK0:      n_state = llbl_pkg::S_CK1;
            llbl_pkg::S_CK1:      n_state = llbl_pkg::S_CK2;
            llbl_pkg::S_CK2:      n_state = llbl_pkg::S_IDLE;
            default:              n_state = llbl_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands and read addresses
    always_comb begin
        mul_req   = '0;
        row_raddr = ROW_AW'(row_sel);
        rec_raddr = '0;
        case (r_state)
            llbl_pkg::S_ROW_MUL: begin
                mul_req.op_a = MW'(r_a);
                mul_req.op_b = MW'(rows_eff);
            end
            llbl_pkg::S_ROW_DIV: begin
                mul_req.op_a = MW'(prod[37:16]);
                mul_req.op_b = llbl_pkg::RECIP_180;
            end
            llbl_pkg::S_COL_MUL: begin
                mul_req.op_a = r_b;
                mul_req.op_b = MW'(rd_size);
            end
            llbl_pkg::S_COL_DIV: begin
                mul_req.op_a = MW'(prod[37:16]);
                mul_req.op_b = llbl_pkg::RECIP_360;
            end
            llbl_pkg::S_BIN:      rec_raddr = REC_AW'(n_eff - S_ONE);
            llbl_pkg::S_END_RD:   rec_raddr = '0;
            llbl_pkg::S_FIRST_RD: rec_raddr = first_mid[REC_AW-1:0];
            llbl_pkg::S_SEARCH: begin
                rec_raddr = search_more ? s_mid[REC_AW-1:0] : s_lo[REC_AW-1:0];
            end
            llbl_pkg::S_CK0: begin
                rec_raddr = REC_AW'(r_lo + S_ONE);
            end
            llbl_pkg::S_CK1: begin
                rec_raddr = REC_AW'(r_lo - S_ONE);
            end
            default: begin
                rec_raddr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= llbl_pkg::S_IDLE;
            r_run_base  <= BIN_ONE;
            r_row_count <= llbl_pkg::DEF_ROW_COUNT;
            r_rec_count <= llbl_pkg::DEF_REC_COUNT;
            r_strobe    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= ((r_state == llbl_pkg::S_BIN) && (n_eff == '0))
                        || (r_state == llbl_pkg::S_CK2);
            if (row_we) begin
                r_run_base <= base_use + BIN_BITS'(size_sat);
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == llbl_pkg::CFG_ROWS) begin
                    r_row_count <= i_cfg_data[12:0];
                end else begin
                    r_rec_count <= i_cfg_data;
                end
            end
        end
    end

    // query payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            llbl_pkg::S_IDLE: begin
                r_a <= a_val[23:0];
                r_b <= b_val[24:0];
            end
            llbl_pkg::S_COL_MUL: begin
                r_size <= rd_size;
                r_base <= rd_base;
            end
            llbl_pkg::S_BIN: begin
                r_bin   <= bin_calc;
                r_found <= 1'b0;
                r_grid  <= 24'(bin_calc);
                r_idx   <= '0;
                r_val   <= '0;
            end
            llbl_pkg::S_END_RD: begin
                r_last_bin <= d_bin;
                r_last_val <= d_val;
            end
            llbl_pkg::S_FIRST_RD: begin
                r_first_bin <= d_bin;
                r_first_val <= d_val;
                r_up        <= (r_last_bin >= d_bin);
                r_lo        <= S_NEG1;
                r_hi        <= n_eff;
                r_mid       <= first_mid;
            end
            llbl_pkg::S_SEARCH: begin
                r_lo  <= s_lo;
                r_hi  <= s_hi;
                r_mid <= s_mid;
            end
            llbl_pkg::S_CK0: begin
                r_c0_bin <= d_bin;
                r_c0_val <= d_val;
            end
            llbl_pkg::S_CK1: begin
                r_c1_bin <= d_bin;
                r_c1_val <= d_val;
            end
            llbl_pkg::S_CK2: begin
                r_found <= hit;
                r_grid  <= 24'(r_bin);
                r_idx   <= hit ? 16'(hit_idx) : 16'd0;
                r_val   <= hit ? hit_val : 32'd0;
            end
            default: begin
                r_found <= r_found;
            end
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_found       = r_found;
    assign o_grid_bin    = r_grid;
    assign o_match_index = r_idx;
    assign o_match_value = r_val;
endmodule
`default_nettype wire

// ----- src/llbl_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module llbl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic [1:0]  i_kind,
    input wire logic        busy,
    input wire logic        o_strobe,
    input wire logic        o_found,
    input wire logic [15:0] o_match_index,
    input wire logic [31:0] o_match_value
);
    // an accepted query always makes the block busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == llbl_pkg::KIND_QUERY)) |=> busy)
        else $error("query accepted without busy");

    // a result word only ends a busy period
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) && !busy))
        else $error("result word outside a query");

    // busy only drops with a result word
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("query ended without result word");

    // miss reports zero slot and value
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> ((o_match_index == '0) && (o_match_value == '0)))
        else $error("miss with nonzero slot or value");
endmodule

bind latlon_bin_lookup llbl_checker u_llbl_checker (.*);
`default_nettype wire
